### rtl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset
`define TMSD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tmsd assertion failed");

// Check on every clock edge, reset included
`define TMSD_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("tmsd assertion failed");

`endif

### rtl/tmsd_pkg.sv
// Shared constants, types and helpers of the text movie stream decoder
`default_nettype none

package tmsd_pkg;

  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 48;

  localparam logic [1:0] EV_CELL  = 2'd0;
  localparam logic [1:0] EV_FRAME = 2'd1;
  localparam logic [1:0] EV_END   = 2'd2;
  localparam logic [1:0] EV_DELAY = 2'd3;

  localparam logic [7:0] SKIP_FIRST  = 8'h80;
  localparam logic [7:0] SKIP_BASE   = 8'h7F;
  localparam logic [7:0] DELAY_FIRST = 8'hD0;
  localparam logic [7:0] DELAY_BASE  = 8'hCF;
  localparam logic [7:0] CMD_FIRST   = 8'hF0;
  localparam logic [7:0] CMD_SIZE    = 8'hF0;
  localparam logic [7:0] CMD_MOVE    = 8'hF1;
  localparam logic [7:0] CMD_NEWLINE = 8'hFD;
  localparam logic [7:0] CMD_FRAME   = 8'hFE;
  localparam logic [7:0] CMD_END     = 8'hFF;

  localparam logic [7:0] ATTR_BYTE  = 8'h07;
  localparam logic [8:0] CURSOR_MAX = 9'd511;

  localparam logic       CFG_WIDTH  = 1'b0;
  localparam logic       CFG_HEIGHT = 1'b1;
  localparam logic [7:0] WIDTH_RST  = 8'd80;
  localparam logic [5:0] HEIGHT_RST = 6'd30;

  typedef struct packed {
    logic [7:0] width;
    logic [5:0] height;
  } tmsd_cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [12:0] index;
    logic [15:0] value;
    logic [5:0]  delay;
  } tmsd_result_t;

  function automatic logic [8:0] sat_cursor(input logic [9:0] sum);
    sat_cursor = (sum > {1'b0, CURSOR_MAX}) ? CURSOR_MAX : sum[8:0];
  endfunction

endpackage

`default_nettype wire

### rtl/tmsd_exec.sv
// Decode state and combinational byte interpretation
`default_nettype none

module tmsd_exec import tmsd_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         fire,
  input  wire logic [7:0]   stream_byte,
  input  wire logic         movie_start,
  input  wire tmsd_cfg_t    cfg,
  output logic              res_valid,
  output tmsd_result_t      res
);

  localparam logic [2:0] PH_CMD    = 3'd0;
  localparam logic [2:0] PH_SIZE_H = 3'd1;
  localparam logic [2:0] PH_SIZE_W = 3'd2;
  localparam logic [2:0] PH_MOVE_R = 3'd3;
  localparam logic [2:0] PH_MOVE_C = 3'd4;

  logic [2:0] phase_r, phase_nxt;
  logic [7:0] farg_r, farg_nxt;
  logic [8:0] row_r, row_nxt;
  logic [8:0] col_r, col_nxt;
  logic [5:0] mtop_r, mtop_nxt;
  logic [6:0] mleft_r, mleft_nxt;
  logic [7:0] pic_h_r, pic_h_nxt;
  logic [7:0] pic_w_r, pic_w_nxt;

  logic [2:0]  phase;
  logic [8:0]  row, col;
  logic [5:0]  mtop;
  logic [6:0]  mleft;
  logic [7:0]  eff_w;
  logic [5:0]  eff_h;
  logic [7:0]  gap_w, gap_h;
  logic        on_screen;
  logic [16:0] row_off;
  logic [17:0] cell_sum;
  logic [7:0]  skip_len, delay_len;

  always_comb begin
    phase = movie_start ? PH_CMD : phase_r;
    row   = movie_start ? '0 : row_r;
    col   = movie_start ? '0 : col_r;
    mtop  = movie_start ? '0 : mtop_r;
    mleft = movie_start ? '0 : mleft_r;

    eff_w = ({1'b0, cfg.width} > 9'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : cfg.width;
    eff_h = ({3'b0, cfg.height} > 9'(MAX_HEIGHT)) ? 6'(MAX_HEIGHT) : cfg.height;

    gap_w = eff_w - stream_byte;
    gap_h = {2'b0, eff_h} - farg_r;

    on_screen = (col < {1'b0, eff_w}) && (row < {3'b0, eff_h});
    row_off   = row * eff_w;
    cell_sum  = {1'b0, row_off} + {9'b0, col};
    skip_len  = stream_byte - SKIP_BASE;
    delay_len = stream_byte - DELAY_BASE;
  end

  always_comb begin
    phase_nxt = phase;
    farg_nxt  = farg_r;
    row_nxt   = row;
    col_nxt   = col;
    mtop_nxt  = mtop;
    mleft_nxt = mleft;
    pic_h_nxt = movie_start ? '0 : pic_h_r;
    pic_w_nxt = movie_start ? '0 : pic_w_r;
    res_valid = 1'b0;
    res       = '0;

    case (phase)
      PH_SIZE_H, PH_MOVE_R: begin
        farg_nxt  = stream_byte;
        phase_nxt = phase + 3'd1;
      end
      PH_SIZE_W: begin
        pic_h_nxt = farg_r;
        pic_w_nxt = stream_byte;
        mleft_nxt = (eff_w > stream_byte) ? gap_w[7:1] : '0;
        mtop_nxt  = ({2'b0, eff_h} > farg_r) ? gap_h[6:1] : '0;
        phase_nxt = PH_CMD;
      end
      PH_MOVE_C: begin
        row_nxt   = sat_cursor({2'b0, farg_r} + {4'b0, mtop});
        col_nxt   = sat_cursor({2'b0, stream_byte} + {3'b0, mleft});
        phase_nxt = PH_CMD;
      end
      default: begin
        phase_nxt = PH_CMD;
        priority if (stream_byte < SKIP_FIRST) begin
          if (on_screen) begin
            res_valid = 1'b1;
            res.kind  = EV_CELL;
            res.index = cell_sum[12:0];
            res.value = {ATTR_BYTE, stream_byte};
            col_nxt   = sat_cursor({1'b0, col} + 10'd1);
          end
        end else if (stream_byte < DELAY_FIRST) begin
          col_nxt = sat_cursor({1'b0, col} + {2'b0, skip_len});
        end else if (stream_byte < CMD_FIRST) begin
          res_valid = 1'b1;
          res.kind  = EV_DELAY;
          res.delay = delay_len[5:0];
        end else begin
          case (stream_byte)
            CMD_SIZE: phase_nxt = PH_SIZE_H;
            CMD_MOVE: phase_nxt = PH_MOVE_R;
            CMD_NEWLINE: begin
              row_nxt = sat_cursor({1'b0, row} + 10'd1);
              col_nxt = {2'b0, mleft};
            end
            CMD_FRAME: begin
              row_nxt   = {3'b0, mtop};
              col_nxt   = {2'b0, mleft};
              res_valid = 1'b1;
              res.kind  = EV_FRAME;
            end
            CMD_END: begin
              res_valid = 1'b1;
              res.kind  = EV_END;
            end
            default: begin
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CMD;
      farg_r  <= '0;
      row_r   <= '0;
      col_r   <= '0;
      mtop_r  <= '0;
      mleft_r <= '0;
      pic_h_r <= '0;
      pic_w_r <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      farg_r  <= farg_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      mtop_r  <= mtop_nxt;
      mleft_r <= mleft_nxt;
      pic_h_r <= pic_h_nxt;
      pic_w_r <= pic_w_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/text_movie_stream_decoder_top.sv
// Top level of the text movie stream decoder: channels, registers and pipeline
//
//  channel | direction | ports
//  --------+-----------+-----------------------------------------------------
//  in      | sink      | in_valid in_ready in_stream_byte in_movie_start
//  out     | source    | out_valid out_ready out_event_kind out_cell_index
//          |           | out_cell_value out_delay_ticks
//  cfg     | sink      | cfg_valid cfg_ready cfg_index cfg_data
//
// One byte per cycle sustained while the output is not stalled. A byte that yields
// a result goes through the input register, then is decoded into the output
// register driving out_valid; the rate rests on the cursor and phase update loop.
// rst_n is synchronous; it clears phase, cursor, margins, picture size and
// restores the screen size to 80 by 30. A stalled output holds the pipeline.
`default_nettype none

module text_movie_stream_decoder_top import tmsd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_stream_byte,
  input  wire logic        in_movie_start,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_event_kind,
  output logic [12:0]      out_cell_index,
  output logic [15:0]      out_cell_value,
  output logic [5:0]       out_delay_ticks,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data
);

  logic         s1_valid_r;
  logic [7:0]   s1_byte_r;
  logic         s1_start_r;
  logic         out_valid_r;
  tmsd_result_t out_r;
  tmsd_cfg_t    cfg_r;
  logic         advance;
  logic         fire;
  logic         res_valid;
  tmsd_result_t res;

  assign advance   = !out_valid_r || out_ready;
  assign fire      = s1_valid_r && advance;
  assign in_ready  = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= WIDTH_RST;
      cfg_r.height <= HEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WIDTH:  cfg_r.width  <= cfg_data;
        CFG_HEIGHT: cfg_r.height <= cfg_data[5:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r  <= in_stream_byte;
      s1_start_r <= in_movie_start;
    end
  end

  tmsd_exec u_exec (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .stream_byte (s1_byte_r),
    .movie_start (s1_start_r),
    .cfg         (cfg_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_kind  = out_r.kind;
  assign out_cell_index  = out_r.index;
  assign out_cell_value  = out_r.value;
  assign out_delay_ticks = out_r.delay;

endmodule

`default_nettype wire

### rtl/tmsd_checker.sv
// Port-level checker of the text movie stream decoder and its bind
`default_nettype none

`include "assert_macros.svh"

module tmsd_checker import tmsd_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_event_kind,
  input wire logic [12:0] out_cell_index,
  input wire logic [15:0] out_cell_value,
  input wire logic [5:0]  out_delay_ticks
);

  `TMSD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_event_kind) && $stable(out_cell_index) && $stable(out_cell_value) && $stable(out_delay_ticks))
  `TMSD_ASSERT(a_event_clean, out_valid && out_event_kind != EV_CELL |-> out_cell_index == 13'd0 && out_cell_value == 16'd0)
  `TMSD_ASSERT(a_cell_word, out_valid && out_event_kind == EV_CELL |-> out_cell_value[15:8] == ATTR_BYTE && out_delay_ticks == 6'd0)
  `TMSD_ASSERT(a_delay_range, out_valid && out_event_kind == EV_DELAY |-> out_delay_ticks != 6'd0 && out_delay_ticks <= 6'd32)
  `TMSD_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid)

endmodule

bind text_movie_stream_decoder_top tmsd_checker u_tmsd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_event_kind  (out_event_kind),
  .out_cell_index  (out_cell_index),
  .out_cell_value  (out_cell_value),
  .out_delay_ticks (out_delay_ticks)
);

`default_nettype wire
